// File: rtl/core/anbx_pkg.sv
// shared types and constants of the annex b start code splitter
package anbx_pkg;

   // header and window geometry
   localparam logic [2:0] HEADER_LEN   = 3'd4;
   localparam logic [1:0] WINDOW_DEPTH = 2'd3;
   localparam logic [7:0] START_BYTE   = 8'h01;
   localparam logic [7:0] ZERO_BYTE    = 8'h00;

   // command queue geometry
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // one command from the classifier: push zeros, push a byte, close the unit
   typedef struct packed {
      logic [2:0] zeros;
      logic       has_byte;
      logic [7:0] data;
      logic       close;
   } anbx_cmd_type;

   // micro-operation of the back end
   typedef enum logic [1:0] {
      OP_NONE,
      OP_ZERO,
      OP_BYTE,
      OP_CLOSE
   } anbx_op_type;

   // status of the back end, watched at the top level
   typedef struct packed {
      logic held_valid;
      logic unit_open;
   } anbx_back_stat_type;

endpackage

// File: rtl/core/anbx_channel_if.sv
// valid/ready channel interfaces for input bytes and output unit bytes
interface anbx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_end;

   modport source (output valid, output data_byte, output frame_end, input ready);
   modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface anbx_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] nal_byte;
   logic       unit_first;
   logic       unit_last;

   modport source (output valid, output nal_byte, output unit_first, output unit_last,
                   input ready);
   modport sink   (input valid, input nal_byte, input unit_first, input unit_last,
                   output ready);
endinterface

// File: rtl/core/anbx_cmd_fifo.sv
// short command queue between the classifier and the unit builder
module anbx_cmd_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  anbx_pkg::anbx_cmd_type push_cmd,
   output logic                  full,
   input  logic                  pop,
   output logic                  pop_valid,
   output anbx_pkg::anbx_cmd_type pop_cmd
);
   import anbx_pkg::*;

   anbx_cmd_type          entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign full      = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   // pointer and count update
   always_comb begin
      wr_ptr_in = do_push ? QUEUE_AW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? QUEUE_AW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = QUEUE_CW'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = QUEUE_CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/core/anbx_front.sv
// classifier: header check, zero-run window, command generation per input byte
module anbx_front (
   input  logic                   clock,
   input  logic                   reset,
   anbx_req_if.sink               req_chan,
   output logic                   cmd_push,
   output anbx_pkg::anbx_cmd_type cmd_data,
   input  logic                   cmd_full
);
   import anbx_pkg::*;

   logic [1:0]   fill_ff, fill_in;
   logic [2:0]   hdr_ff, hdr_in;
   logic         rej_ff, rej_in;
   logic         accept;
   logic [7:0]   expect_byte;
   anbx_cmd_type cmd;

   assign req_chan.ready = !cmd_full;
   assign accept         = req_chan.valid && !cmd_full;

   // classify one byte into a command and the next frame state
   always_comb begin
      cmd         = '0;
      fill_in     = fill_ff;
      hdr_in      = hdr_ff;
      rej_in      = rej_ff;
      expect_byte = (hdr_ff == HEADER_LEN - 3'd1) ? START_BYTE : ZERO_BYTE;
      if (hdr_ff != HEADER_LEN) begin
         // header byte
         if (req_chan.data_byte != expect_byte) begin
            rej_in = 1'b1;
         end
         hdr_in = hdr_ff + 3'd1;
      end else if (!rej_ff) begin
         if (req_chan.data_byte == ZERO_BYTE) begin
            // zero: grow the window or shift its oldest zero out
            if (fill_ff != WINDOW_DEPTH) begin
               fill_in = fill_ff + 2'd1;
            end else begin
               cmd.zeros = 3'd1;
            end
         end else if (req_chan.data_byte == START_BYTE && fill_ff == WINDOW_DEPTH) begin
            // start code found
            fill_in   = '0;
            cmd.close = 1'b1;
         end else begin
            // ordinary byte: flush pending zeros then the byte
            cmd.zeros    = {1'b0, fill_ff};
            cmd.has_byte = 1'b1;
            cmd.data     = req_chan.data_byte;
            fill_in      = '0;
         end
      end
      // frame end flushes the window and closes the unit if the header was good
      if (req_chan.frame_end) begin
         if (!rej_in && hdr_in == HEADER_LEN) begin
            cmd.zeros = cmd.zeros + {1'b0, fill_in};
            cmd.close = 1'b1;
         end
         fill_in = '0;
         hdr_in  = '0;
         rej_in  = 1'b0;
      end
   end

   assign cmd_data = cmd;
   assign cmd_push = accept && (cmd.zeros != 3'd0 || cmd.has_byte || cmd.close);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         hdr_ff  <= '0;
         rej_ff  <= 1'b0;
      end else if (accept) begin
         fill_ff <= fill_in;
         hdr_ff  <= hdr_in;
         rej_ff  <= rej_in;
      end
   end

endmodule

// File: rtl/core/anbx_back.sv
// unit builder: runs commands, holds one byte back to mark the unit end
module anbx_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_valid,
   input  anbx_pkg::anbx_cmd_type       cmd_data,
   output logic                         cmd_pop,
   anbx_rsp_if.source                   rsp_chan,
   output anbx_pkg::anbx_back_stat_type stat
);
   import anbx_pkg::*;

   anbx_cmd_type cur_ff, cur_in, rem;
   logic         cur_valid_ff, cur_valid_in;
   logic [7:0]   held_byte_ff, held_byte_in;
   logic         held_valid_ff, held_valid_in;
   logic         held_first_ff, held_first_in;
   logic         open_ff, open_in;
   logic         out_valid_ff, out_valid_in;
   logic [7:0]   out_byte_ff, out_byte_in;
   logic         out_first_ff, out_first_in;
   logic         out_last_ff, out_last_in;
   anbx_op_type  op;
   logic         out_free, go, rem_empty, take;

   // pick the next micro-operation of the current command
   always_comb begin
      op = OP_NONE;
      if (cur_valid_ff) begin
         priority if (cur_ff.zeros != 3'd0) begin
            op = OP_ZERO;
         end else if (cur_ff.has_byte) begin
            op = OP_BYTE;
         end else if (cur_ff.close) begin
            op = OP_CLOSE;
         end
      end
   end

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign go       = (op != OP_NONE) && (!held_valid_ff || out_free);

   // execute the micro-operation and load the next command
   always_comb begin
      rem           = cur_ff;
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      held_first_in = held_first_ff;
      open_in       = open_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_byte_in   = out_byte_ff;
      out_first_in  = out_first_ff;
      out_last_in   = out_last_ff;
      unique case (op)
         OP_ZERO:  rem.zeros    = cur_ff.zeros - 3'd1;
         OP_BYTE:  rem.has_byte = 1'b0;
         OP_CLOSE: rem.close    = 1'b0;
         default:  rem          = cur_ff;
      endcase
      if (go) begin
         // the held byte leaves when a new byte arrives or the unit closes
         if (held_valid_ff) begin
            out_valid_in = 1'b1;
            out_byte_in  = held_byte_ff;
            out_first_in = held_first_ff;
            out_last_in  = (op == OP_CLOSE);
         end
         if (op == OP_CLOSE) begin
            held_valid_in = 1'b0;
            open_in       = 1'b0;
         end else begin
            held_byte_in  = (op == OP_ZERO) ? ZERO_BYTE : cur_ff.data;
            held_first_in = !open_ff;
            held_valid_in = 1'b1;
            open_in       = 1'b1;
         end
      end
      rem_empty    = (rem.zeros == 3'd0) && !rem.has_byte && !rem.close;
      take         = (op == OP_NONE) || (go && rem_empty);
      cur_in       = go ? rem : cur_ff;
      cur_valid_in = cur_valid_ff;
      if (take) begin
         cur_in       = cmd_data;
         cur_valid_in = cmd_valid;
      end
   end

   assign cmd_pop = take && cmd_valid;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff  <= 1'b0;
         held_valid_ff <= 1'b0;
         open_ff       <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         cur_valid_ff  <= cur_valid_in;
         held_valid_ff <= held_valid_in;
         open_ff       <= open_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      held_byte_ff  <= held_byte_in;
      held_first_ff <= held_first_in;
      out_byte_ff   <= out_byte_in;
      out_first_ff  <= out_first_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.nal_byte   = out_byte_ff;
   assign rsp_chan.unit_first = out_first_ff;
   assign rsp_chan.unit_last  = out_last_ff;

   assign stat.held_valid = held_valid_ff;
   assign stat.unit_open  = open_ff;

endmodule

// File: rtl/core/annexb_nal_splitter_core.sv
// top level of the annex b start code splitter
// Usage: bytes of one access unit enter on req_chan (data_byte, frame_end on the
// last byte), one transaction per cycle when ready is high. The frame must open
// with 00 00 00 01, else the whole frame is dropped. Unit bytes leave on rsp_chan
// with unit_first/unit_last marks; four-byte start codes are removed, empty units
// skipped. Throughput: one input byte per cycle while the queue has room. The
// classifier turns each byte into a command for a 4-entry queue; the unit builder
// retires one released byte per cycle while rsp_chan takes its output, so a byte
// that releases several (a broken zero run, the frame end) is absorbed by the
// queue. A byte is held until the next byte or the unit end decides its last
// mark; once released it reaches rsp_chan through the queue, the command and the output register.
// Reset (synchronous, active high) empties the queue, the output register and
// all frame state; no clearing pass is needed.
// When the receiver stalls, the output register holds its transaction, the
// builder stops, the queue fills and req_chan.ready drops when it is full.
module annexb_nal_splitter_core (
   input  logic       clock,
   input  logic       reset,
   anbx_req_if.sink   req_chan,
   anbx_rsp_if.source rsp_chan
);
   import anbx_pkg::*;

   logic               cmd_push, cmd_full, cmd_pop, cmd_valid;
   anbx_cmd_type       push_cmd, pop_cmd;
   anbx_back_stat_type back_stat;

   anbx_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .cmd_push (cmd_push),
      .cmd_data (push_cmd),
      .cmd_full (cmd_full)
   );

   anbx_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_cmd  (push_cmd),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_valid (cmd_valid),
      .pop_cmd   (pop_cmd)
   );

   anbx_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (pop_cmd),
      .cmd_pop   (cmd_pop),
      .rsp_chan  (rsp_chan),
      .stat      (back_stat)
   );

   // a held byte always belongs to an open unit
   assert property (@(posedge clock) disable iff (reset)
      back_stat.held_valid |-> back_stat.unit_open)
      else $error("held byte outside an open unit");

   // the classifier never writes a full queue
   assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !cmd_full)
      else $error("command pushed into a full queue");

   // reset empties the queue and the output register
   assert property (@(posedge clock)
      reset |=> !cmd_valid && !rsp_chan.valid && !back_stat.held_valid)
      else $error("state left after reset");

endmodule

// File: test/annexb_nal_splitter_core_tb.sv
// self-checking testbench of the annex b start code splitter core
module annexb_nal_splitter_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import anbx_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_PCT    = 23;

   // one expected byte of a network abstraction layer unit
   typedef struct {
      logic [7:0] nal_byte;
      logic       unit_first;
      logic       unit_last;
   } unit_byte_type;

   logic clock;
   logic reset;

   anbx_req_if req_bus ();
   anbx_rsp_if rsp_bus ();

   annexb_nal_splitter_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // expected unit bytes, oldest first
   unit_byte_type unit_bytes_pending[$];

   // splitter state mirrored by the predictor
   logic [7:0] zero_window [3];
   logic [1:0] zero_fill;
   logic [2:0] header_seen;
   logic       header_bad;
   logic [7:0] hold_byte;
   logic       hold_valid;
   logic       hold_first;
   logic       in_unit;

   // run bookkeeping
   int  cycle_count   = 0;
   int  mismatches    = 0;
   int  bytes_sent    = 0;
   int  frames_sent   = 0;
   int  bytes_checked = 0;
   int  units_checked = 0;
   bit  no_idle       = 1'b0;

   // clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // predictor
   function automatic void emit_unit_byte(input logic [7:0] b, input logic f, input logic l);
      unit_byte_type u;
      u.nal_byte   = b;
      u.unit_first = f;
      u.unit_last  = l;
      unit_bytes_pending.push_back(u);
   endfunction

   function automatic void hold_payload(input logic [7:0] b);
      if (hold_valid) emit_unit_byte(hold_byte, hold_first, 1'b0);
      hold_byte  = b;
      hold_first = !in_unit;
      in_unit    = 1'b1;
      hold_valid = 1'b1;
   endfunction

   function automatic void end_unit();
      if (hold_valid) emit_unit_byte(hold_byte, hold_first, 1'b1);
      hold_valid = 1'b0;
      in_unit    = 1'b0;
   endfunction

   function automatic void release_window();
      for (int i = 0; i < zero_fill; i++) hold_payload(zero_window[i]);
      zero_fill = '0;
   endfunction

   function automatic void clear_frame_state();
      for (int i = 0; i < 3; i++) zero_window[i] = ZERO_BYTE;
      zero_fill   = '0;
      header_seen = '0;
      header_bad  = 1'b0;
      hold_byte   = ZERO_BYTE;
      hold_valid  = 1'b0;
      hold_first  = 1'b0;
      in_unit     = 1'b0;
   endfunction

   function automatic void predict_split(input logic [7:0] b, input logic fe);
      logic [7:0] want;
      if (header_seen < HEADER_LEN) begin
         want = (header_seen == HEADER_LEN - 1) ? START_BYTE : ZERO_BYTE;
         if (b != want) header_bad = 1'b1;
         header_seen = header_seen + 3'd1;
      end else if (!header_bad) begin
         if (b == ZERO_BYTE) begin
            if (zero_fill < WINDOW_DEPTH) begin
               zero_window[zero_fill] = ZERO_BYTE;
               zero_fill = zero_fill + 2'd1;
            end else begin
               hold_payload(zero_window[0]);
               zero_window[0] = zero_window[1];
               zero_window[1] = zero_window[2];
               zero_window[2] = b;
            end
         end else if (b == START_BYTE && zero_fill == WINDOW_DEPTH) begin
            zero_fill = '0;
            end_unit();
         end else begin
            release_window();
            hold_payload(b);
         end
      end
      // frame end flushes whatever is pending
      if (fe) begin
         if (!header_bad && header_seen >= HEADER_LEN) begin
            release_window();
            end_unit();
         end
         clear_frame_state();
      end
   endfunction

   // result side: random backpressure, checked at the rising edge
   initial rsp_bus.ready = 1'b0;

   always @(negedge clock) begin
      rsp_bus.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      unit_byte_type u;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (unit_bytes_pending.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected transaction byte=%02h first=%0b last=%0b", $time,
                     rsp_bus.nal_byte, rsp_bus.unit_first, rsp_bus.unit_last);
         end else begin
            u = unit_bytes_pending.pop_front();
            bytes_checked++;
            if (u.unit_last) units_checked++;
            if (rsp_bus.nal_byte !== u.nal_byte) begin
               mismatches++;
               $display("%0t: nal_byte expected %02h actual %02h", $time,
                        u.nal_byte, rsp_bus.nal_byte);
            end
            if (rsp_bus.unit_first !== u.unit_first) begin
               mismatches++;
               $display("%0t: unit_first expected %0b actual %0b", $time,
                        u.unit_first, rsp_bus.unit_first);
            end
            if (rsp_bus.unit_last !== u.unit_last) begin
               mismatches++;
               $display("%0t: unit_last expected %0b actual %0b", $time,
                        u.unit_last, rsp_bus.unit_last);
            end
         end
      end
   end

   // input side: one transaction, with an optional random gap ahead of it
   task automatic send_item(input logic [7:0] b, input logic fe);
      if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(0, 3)) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      req_bus.frame_end <= fe;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_split(b, fe);
      bytes_sent++;
      if (fe) frames_sent++;
   endtask

   task automatic send_frame(input logic [7:0] frame_bytes[$]);
      for (int i = 0; i < frame_bytes.size(); i++)
         send_item(frame_bytes[i], i == frame_bytes.size() - 1);
   endtask

   // hold the input idle until every expected byte is out
   task automatic wait_for_drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (unit_bytes_pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // build and send one random frame, mostly well formed
   task automatic send_random_frame(output int n_bytes);
      logic [7:0] fr[$];
      logic [7:0] v;
      int kind, len, k, pick;
      kind = $urandom_range(0, 99);
      fr   = '{ZERO_BYTE, ZERO_BYTE, ZERO_BYTE, START_BYTE};
      if (kind < 12) begin
         // corrupt one header byte, then some payload that must be dropped
         k = $urandom_range(0, 3);
         do v = 8'($urandom_range(0, 255)); while (v == fr[k]);
         fr[k] = v;
         len = $urandom_range(0, 6);
         repeat (len) fr.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 20) begin
         // frame that ends inside or right after the header
         len = $urandom_range(1, 4);
         while (fr.size() > len) void'(fr.pop_back());
      end else begin
         len = $urandom_range(1, 12);
         for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) fr.push_back(ZERO_BYTE);
            else if (pick < 50) fr.push_back(START_BYTE);
            else if (pick < 62) begin
               repeat ($urandom_range(3, 5)) fr.push_back(ZERO_BYTE);
               fr.push_back(START_BYTE);
            end else fr.push_back(8'($urandom_range(0, 255)));
         end
      end
      send_frame(fr);
      n_bytes = fr.size();
   endtask

   // extremes of the byte and every named corner case
   task automatic test_directed_frames();
      // payload, zero run ahead of a start code, empty unit, start code at the end
      send_frame('{8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
                   8'h01, 8'h00, 8'h00, 8'h00, 8'h01});
      // bad header that ends during the header
      send_frame('{8'h00, 8'h00, 8'h01});
      // header only
      send_frame('{8'h00, 8'h00, 8'h00, 8'h01});
      // trailing start code prefix stays in the final unit
      send_frame('{8'h00, 8'h00, 8'h00, 8'h01, 8'h7F, 8'h00, 8'h00});
   endtask

   // random frames, with one full drain in the middle
   task automatic test_random_frames(input int n_items);
      int done, n;
      bit drained;
      done    = 0;
      drained = 1'b0;
      while (done < n_items) begin
         send_random_frame(n);
         done += n;
         if (!drained && done >= n_items / 2) begin
            wait_for_drain();
            drained = 1'b1;
         end
      end
   endtask

   // full rate on both sides
   task automatic test_back_to_back(input int n_items);
      int done, n;
      done    = 0;
      no_idle = 1'b1;
      while (done < n_items) begin
         send_random_frame(n);
         done += n;
      end
      no_idle = 1'b0;
   endtask

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("annexb_nal_splitter_core regression: fail");
      $finish;
   end

   // main sequence
   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = '0;
      req_bus.frame_end = 1'b0;
      clear_frame_state();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_frames();
      test_random_frames(150);
      test_back_to_back(70);

      wait_for_drain();
      repeat (10) @(posedge clock);

      $display("covered %0d frames, %0d input bytes, %0d unit bytes in %0d units checked",
               frames_sent, bytes_sent, bytes_checked, units_checked);
      $display("random stalls on both sides, one drain pause and a full rate stretch");
      if (mismatches == 0 && unit_bytes_pending.size() == 0)
         $display("annexb_nal_splitter_core regression: pass");
      else
         $display("annexb_nal_splitter_core regression: fail");
      $finish;
   end

endmodule
